>>> src/dali_pkg.sv
// Shared types, register map and codes for the DALI frame transceiver.
package dali_pkg;

   // Command kinds carried on the request tuser
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_SEND = 2'd1;
   localparam logic [1:0] FUNC_RECV = 2'd2;

   // Event kinds carried on the response tuser
   localparam logic [1:0] EV_NONE       = 2'd0;
   localparam logic [1:0] EV_FRAME_SENT = 2'd1;
   localparam logic [1:0] EV_BYTE_RECV  = 2'd2;
   localparam logic [1:0] EV_TIMEOUT    = 2'd3;

   // Register indexes (byte address is four times the index)
   localparam logic [2:0] REG_TX_HALF    = 3'd0;
   localparam logic [2:0] REG_RX_BIT     = 3'd1;
   localparam logic [2:0] REG_RX_HALF    = 3'd2;
   localparam logic [2:0] REG_RX_QUARTER = 3'd3;
   localparam logic [2:0] REG_STOP       = 3'd4;
   localparam logic [2:0] REG_TICKS_MS   = 3'd5;

   // Register reset values
   localparam logic [11:0] TX_HALF_RST    = 12'd410;
   localparam logic [11:0] RX_BIT_RST     = 12'd833;
   localparam logic [11:0] RX_HALF_RST    = 12'd416;
   localparam logic [11:0] RX_QUARTER_RST = 12'd208;
   localparam logic [15:0] STOP_RST       = 16'd3332;
   localparam logic [15:0] TICKS_MS_RST   = 16'd1000;

   // Forward frame length: start bit, address byte, data byte
   localparam int unsigned FRAME_BITS = 17;

   typedef struct packed {
      logic [11:0] tx_half_ticks;
      logic [11:0] rx_bit_ticks;
      logic [11:0] rx_half_ticks;
      logic [11:0] rx_quarter_ticks;
      logic [15:0] stop_ticks;
      logic [15:0] ticks_per_ms;
   } dali_cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  frame_address;
      logic [7:0]  frame_data;
      logic [15:0] wait_ms;
      logic        rx_level;
   } dali_cmd_type;

   typedef struct packed {
      logic       tx_level;
      logic       busy_res;
      logic [1:0] event_res;
      logic [7:0] rx_data;
   } dali_rsp_type;

endpackage

>>> src/dali_engine.sv
// Transmit and receive sequencer: state registers and next-state logic for one word.
module dali_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dali_pkg::dali_cmd_type cmd,
   input  dali_pkg::dali_cfg_type cfg,
   output dali_pkg::dali_rsp_type result
);
   import dali_pkg::*;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_TX_BITS   = 3'd1;
   localparam logic [2:0] PH_TX_STOP   = 3'd2;
   localparam logic [2:0] PH_RX_HIGH   = 3'd3;
   localparam logic [2:0] PH_RX_LOW    = 3'd4;
   localparam logic [2:0] PH_RX_SAMPLE = 3'd5;
   localparam logic [2:0] PH_RX_FINAL  = 3'd6;

   localparam logic [4:0] LAST_BIT = 5'(FRAME_BITS - 1);
   localparam logic [4:0] FRAME_END = 5'(FRAME_BITS);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [4:0]  bit_index_ff, bit_index_in;
   logic        second_half_ff, second_half_in;
   logic [16:0] tx_bits_ff, tx_bits_in;
   logic [7:0]  rx_bits_ff, rx_bits_in;
   logic [31:0] wait_elapsed_ff, wait_elapsed_in;
   logic [31:0] wait_limit_ff, wait_limit_in;
   logic        drive_ff, drive_in;

   logic [15:0] tick_inc;
   logic [31:0] wait_inc;
   logic [4:0]  bit_next;
   logic [13:0] first_target;
   logic [15:0] sample_target;
   logic [1:0]  event_code;
   logic [7:0]  byte_out;

   // Frame bit at a given position, MSB first; zero past the end of the frame.
   function automatic logic frame_bit(input logic [16:0] bits, input logic [4:0] idx);
      logic [4:0] pos;
      pos = LAST_BIT - idx;
      frame_bit = (idx < FRAME_END) ? bits[pos] : 1'b0;
   endfunction

   // Saturating counters and sample targets.
   assign tick_inc      = (tick_count_ff != 16'hFFFF) ? tick_count_ff + 16'd1 : tick_count_ff;
   assign wait_inc      = (wait_elapsed_ff != 32'hFFFF_FFFF) ? wait_elapsed_ff + 32'd1
                                                              : wait_elapsed_ff;
   assign bit_next      = bit_index_ff + 5'd1;
   assign first_target  = 14'(cfg.rx_bit_ticks) + 14'(cfg.rx_half_ticks)
                        + 14'(cfg.rx_quarter_ticks);
   assign sample_target = (bit_index_ff == 5'd0) ? 16'(first_target) : 16'(cfg.rx_bit_ticks);

   // Next state for the word presented this cycle.
   always_comb begin
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      bit_index_in    = bit_index_ff;
      second_half_in  = second_half_ff;
      tx_bits_in      = tx_bits_ff;
      rx_bits_in      = rx_bits_ff;
      wait_elapsed_in = wait_elapsed_ff;
      wait_limit_in   = wait_limit_ff;
      drive_in        = drive_ff;
      event_code      = EV_NONE;
      byte_out        = 8'd0;
      if (cmd.func == FUNC_SEND && phase_ff == PH_IDLE) begin
         tx_bits_in     = {1'b1, cmd.frame_address, cmd.frame_data};
         bit_index_in   = 5'd0;
         second_half_in = 1'b0;
         tick_count_in  = 16'd0;
         drive_in       = 1'b1;
         phase_in       = PH_TX_BITS;
      end else if (cmd.func == FUNC_RECV && phase_ff == PH_IDLE) begin
         wait_limit_in   = 32'(cmd.wait_ms) * 32'(cfg.ticks_per_ms);
         wait_elapsed_in = 32'd0;
         phase_in        = PH_RX_HIGH;
      end else if (cmd.func == FUNC_TICK) begin
         case (phase_ff)
            PH_TX_BITS: begin
               tick_count_in = tick_inc;
               if (tick_inc >= 16'(cfg.tx_half_ticks)) begin
                  tick_count_in = 16'd0;
                  if (!second_half_ff) begin
                     second_half_in = 1'b1;
                     drive_in       = ~frame_bit(tx_bits_ff, bit_index_ff);
                  end else begin
                     second_half_in = 1'b0;
                     bit_index_in   = bit_next;
                     if (bit_next >= FRAME_END) begin
                        phase_in = PH_TX_STOP;
                        drive_in = 1'b0;
                     end else begin
                        drive_in = frame_bit(tx_bits_ff, bit_next);
                     end
                  end
               end
            end
            PH_TX_STOP: begin
               tick_count_in = tick_inc;
               if (tick_inc >= cfg.stop_ticks) begin
                  tick_count_in = 16'd0;
                  phase_in      = PH_IDLE;
                  event_code    = EV_FRAME_SENT;
               end
            end
            PH_RX_HIGH, PH_RX_LOW: begin
               wait_elapsed_in = wait_inc;
               if (phase_ff == PH_RX_HIGH && cmd.rx_level) begin
                  phase_in = PH_RX_LOW;
               end else if (phase_ff == PH_RX_LOW && !cmd.rx_level) begin
                  phase_in      = PH_RX_SAMPLE;
                  tick_count_in = 16'd0;
                  bit_index_in  = 5'd0;
                  rx_bits_in    = 8'd0;
               end else if (wait_inc >= wait_limit_ff) begin
                  phase_in   = PH_IDLE;
                  event_code = EV_TIMEOUT;
               end
            end
            PH_RX_SAMPLE: begin
               tick_count_in = tick_inc;
               if (tick_inc >= sample_target) begin
                  tick_count_in = 16'd0;
                  rx_bits_in    = {rx_bits_ff[6:0], cmd.rx_level};
                  bit_index_in  = bit_next;
                  if (bit_next >= 5'd8) begin
                     phase_in = PH_RX_FINAL;
                  end
               end
            end
            PH_RX_FINAL: begin
               tick_count_in = tick_inc;
               if (tick_inc >= 16'(cfg.rx_bit_ticks)) begin
                  tick_count_in = 16'd0;
                  phase_in      = PH_IDLE;
                  event_code    = EV_BYTE_RECV;
                  byte_out      = rx_bits_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state is cleared by reset; the shift and limit registers need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_count_ff   <= 16'd0;
         bit_index_ff    <= 5'd0;
         second_half_ff  <= 1'b0;
         wait_elapsed_ff <= 32'd0;
         drive_ff        <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         tick_count_ff   <= tick_count_in;
         bit_index_ff    <= bit_index_in;
         second_half_ff  <= second_half_in;
         wait_elapsed_ff <= wait_elapsed_in;
         drive_ff        <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         tx_bits_ff    <= tx_bits_in;
         rx_bits_ff    <= rx_bits_in;
         wait_limit_ff <= wait_limit_in;
      end
   end

   // Result of this word, taken by the output register in the top level.
   assign result.tx_level  = drive_in;
   assign result.busy_res  = (phase_in != PH_IDLE);
   assign result.event_res = event_code;
   assign result.rx_data   = byte_out;

   // The transmit index never runs past the frame while bits are being sent.
   a_tx_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TX_BITS |-> bit_index_ff < FRAME_END)
      else $error("transmit bit index beyond frame");

   // The receive index stays within the byte while sampling.
   a_rx_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RX_SAMPLE |-> bit_index_ff < 5'd8)
      else $error("receive bit index beyond byte");

   // The bus is released whenever no bits are being sent.
   a_release: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_TX_BITS |-> !drive_ff)
      else $error("bus driven outside of frame bits");

   // A command while busy leaves the sequencer where it was.
   a_busy_cmd: assert property (@(posedge clock) disable iff (reset)
      (step && cmd.func != FUNC_TICK && phase_ff != PH_IDLE)
      |=> phase_ff == $past(phase_ff))
      else $error("command disturbed a busy sequencer");

endmodule

>>> src/dali_frame_transceiver_core.sv
// Top level of the DALI frame transceiver: stream ports, register port, output register.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------------
//   req_     | in        | tuser func; tdata address, data, wait_ms, rx_level
//   rsp_     | out       | tuser event_res; tdata tx_level, busy_res, rx_data
//   csr_     | in/out    | six timing registers at byte addresses 0x00 to 0x14
//
// The sequencer computes the result of each word in the cycle
// it is accepted and the result register holds it for the response side.
// One response word per request word, so a new word is taken in every cycle
// unless a response is waiting and rsp_tready is low.
// Synchronous reset returns the sequencer to idle and the registers to their
// default timing; a stalled response holds its word until it is taken.
module dali_frame_transceiver_core (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // frame_address[7:0], frame_data[15:8],
                                   // wait_ms[31:16], rx_level[32], zero fill
   input  logic [1:0]  req_tuser,  // func[1:0]
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // tx_level[0], busy_res[1], rx_data[9:2], zero fill
   output logic [1:0]  rsp_tuser,  // event_res[1:0]
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dali_pkg::*;

   dali_cfg_type cfg_ff;
   dali_cmd_type cmd;
   dali_rsp_type result;
   logic         step;
   logic         csr_write;
   logic [2:0]   csr_index;
   logic         rsp_valid_ff;
   logic [15:0]  rsp_tdata_ff;
   logic [1:0]   rsp_tuser_ff;

   // Register port: writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_half_ticks    <= TX_HALF_RST;
         cfg_ff.rx_bit_ticks     <= RX_BIT_RST;
         cfg_ff.rx_half_ticks    <= RX_HALF_RST;
         cfg_ff.rx_quarter_ticks <= RX_QUARTER_RST;
         cfg_ff.stop_ticks       <= STOP_RST;
         cfg_ff.ticks_per_ms     <= TICKS_MS_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_TX_HALF:    cfg_ff.tx_half_ticks    <= csr_pwdata[11:0];
            REG_RX_BIT:     cfg_ff.rx_bit_ticks     <= csr_pwdata[11:0];
            REG_RX_HALF:    cfg_ff.rx_half_ticks    <= csr_pwdata[11:0];
            REG_RX_QUARTER: cfg_ff.rx_quarter_ticks <= csr_pwdata[11:0];
            REG_STOP:       cfg_ff.stop_ticks       <= csr_pwdata[15:0];
            REG_TICKS_MS:   cfg_ff.ticks_per_ms     <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         REG_TX_HALF:    csr_prdata = 32'(cfg_ff.tx_half_ticks);
         REG_RX_BIT:     csr_prdata = 32'(cfg_ff.rx_bit_ticks);
         REG_RX_HALF:    csr_prdata = 32'(cfg_ff.rx_half_ticks);
         REG_RX_QUARTER: csr_prdata = 32'(cfg_ff.rx_quarter_ticks);
         REG_STOP:       csr_prdata = 32'(cfg_ff.stop_ticks);
         REG_TICKS_MS:   csr_prdata = 32'(cfg_ff.ticks_per_ms);
         default:        csr_prdata = 32'd0;
      endcase
   end

   // Unpack the request word.
   assign cmd.func          = req_tuser;
   assign cmd.frame_address = req_tdata[7:0];
   assign cmd.frame_data    = req_tdata[15:8];
   assign cmd.wait_ms       = req_tdata[31:16];
   assign cmd.rx_level      = req_tdata[32];

   // A word is taken whenever the response register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   dali_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cmd    (cmd),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_tdata_ff <= {6'd0, result.rx_data, result.busy_res, result.tx_level};
         rsp_tuser_ff <= result.event_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> tb/dali_frame_transceiver_checker.sv
// Checker for the DALI frame transceiver: tracks registers, predicts each response word.
`timescale 1ns / 100ps

module dali_frame_transceiver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // frame_address[7:0], frame_data[15:8],
                                    // wait_ms[31:16], rx_level[32], zero fill
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // tx_level[0], busy_res[1], rx_data[9:2], zero fill
   input  logic [1:0]  rsp_tuser,   // event_res[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   input  logic        end_of_test,
   output int          failures
);
   import dali_pkg::*;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_TX_BITS,
      SEQ_TX_STOP,
      SEQ_RX_HIGH,
      SEQ_RX_LOW,
      SEQ_RX_SAMPLE,
      SEQ_RX_FINAL
   } seq_phase_type;

   // Shadow of the timing registers and of the sequencer state.
   dali_cfg_type  timing;
   seq_phase_type phase;
   int unsigned   tick_cnt;
   int unsigned   bit_idx;
   logic          second_half;
   logic [16:0]   frame_bits;
   logic [7:0]    shift_byte;
   logic [31:0]   wait_elapsed;
   logic [31:0]   wait_limit;
   logic          drive_level;

   // Response words still owed by the block, oldest first.
   dali_rsp_type  owed_rsp[$];
   logic          leftover_checked;

   initial begin
      failures = 0;
      leftover_checked = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (failures < 40) begin
         $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
      end
      failures++;
   endtask

   task automatic clear_sequencer();
      timing.tx_half_ticks    = TX_HALF_RST;
      timing.rx_bit_ticks     = RX_BIT_RST;
      timing.rx_half_ticks    = RX_HALF_RST;
      timing.rx_quarter_ticks = RX_QUARTER_RST;
      timing.stop_ticks       = STOP_RST;
      timing.ticks_per_ms     = TICKS_MS_RST;
      phase        = SEQ_IDLE;
      tick_cnt     = 0;
      bit_idx      = 0;
      second_half  = 1'b0;
      frame_bits   = '0;
      shift_byte   = '0;
      wait_elapsed = '0;
      wait_limit   = '0;
      drive_level  = 1'b0;
   endtask

   task automatic write_timing(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_TX_HALF:    timing.tx_half_ticks    = value[11:0];
         REG_RX_BIT:     timing.rx_bit_ticks     = value[11:0];
         REG_RX_HALF:    timing.rx_half_ticks    = value[11:0];
         REG_RX_QUARTER: timing.rx_quarter_ticks = value[11:0];
         REG_STOP:       timing.stop_ticks       = value[15:0];
         REG_TICKS_MS:   timing.ticks_per_ms     = value[15:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] read_timing(input logic [2:0] idx);
      case (idx)
         REG_TX_HALF:    return {20'b0, timing.tx_half_ticks};
         REG_RX_BIT:     return {20'b0, timing.rx_bit_ticks};
         REG_RX_HALF:    return {20'b0, timing.rx_half_ticks};
         REG_RX_QUARTER: return {20'b0, timing.rx_quarter_ticks};
         REG_STOP:       return {16'b0, timing.stop_ticks};
         REG_TICKS_MS:   return {16'b0, timing.ticks_per_ms};
         default:        return '0;
      endcase
   endfunction

   // The phase counter saturates instead of wrapping.
   task automatic bump_ticks();
      if (tick_cnt < 32'h0000_FFFF) begin
         tick_cnt++;
      end
   endtask

   // Advances the sequencer by one request word and works out its response word.
   task automatic predict_word(input dali_cmd_type cmd, output dali_rsp_type rsp);
      logic [1:0]  ev;
      logic [7:0]  byte_out;
      int unsigned target;
      ev = EV_NONE;
      byte_out = '0;
      if (cmd.func == FUNC_SEND && phase == SEQ_IDLE) begin
         frame_bits  = {1'b1, cmd.frame_address, cmd.frame_data};
         bit_idx     = 0;
         second_half = 1'b0;
         tick_cnt    = 0;
         drive_level = frame_bits[16];
         phase       = SEQ_TX_BITS;
      end else if (cmd.func == FUNC_RECV && phase == SEQ_IDLE) begin
         wait_limit   = 32'(cmd.wait_ms) * 32'(timing.ticks_per_ms);
         wait_elapsed = '0;
         phase        = SEQ_RX_HIGH;
      end else if (cmd.func == FUNC_TICK) begin
         case (phase)
            SEQ_TX_BITS: begin
               bump_ticks();
               if (tick_cnt >= int'(timing.tx_half_ticks)) begin
                  tick_cnt = 0;
                  if (!second_half) begin
                     // Manchester: the second half carries the complement.
                     second_half = 1'b1;
                     drive_level = ~frame_bits[16 - bit_idx];
                  end else begin
                     second_half = 1'b0;
                     bit_idx++;
                     if (bit_idx >= FRAME_BITS) begin
                        phase = SEQ_TX_STOP;
                        drive_level = 1'b0;
                     end else begin
                        drive_level = frame_bits[16 - bit_idx];
                     end
                  end
               end
            end
            SEQ_TX_STOP: begin
               bump_ticks();
               if (tick_cnt >= int'(timing.stop_ticks)) begin
                  tick_cnt = 0;
                  phase = SEQ_IDLE;
                  ev = EV_FRAME_SENT;
               end
            end
            SEQ_RX_HIGH, SEQ_RX_LOW: begin
               // Both waits share one elapsed counter and one limit.
               if (wait_elapsed != 32'hFFFF_FFFF) begin
                  wait_elapsed++;
               end
               if (phase == SEQ_RX_HIGH && cmd.rx_level) begin
                  phase = SEQ_RX_LOW;
               end else if (phase == SEQ_RX_LOW && !cmd.rx_level) begin
                  phase = SEQ_RX_SAMPLE;
                  tick_cnt = 0;
                  bit_idx = 0;
                  shift_byte = '0;
               end else if (wait_elapsed >= wait_limit) begin
                  phase = SEQ_IDLE;
                  ev = EV_TIMEOUT;
               end
            end
            SEQ_RX_SAMPLE: begin
               // The first sample lands in the second half of the first data bit.
               if (bit_idx == 0) begin
                  target = int'(timing.rx_bit_ticks) + int'(timing.rx_half_ticks)
                           + int'(timing.rx_quarter_ticks);
               end else begin
                  target = int'(timing.rx_bit_ticks);
               end
               bump_ticks();
               if (tick_cnt >= target) begin
                  tick_cnt = 0;
                  shift_byte = {shift_byte[6:0], cmd.rx_level};
                  bit_idx++;
                  if (bit_idx >= 8) begin
                     phase = SEQ_RX_FINAL;
                  end
               end
            end
            SEQ_RX_FINAL: begin
               bump_ticks();
               if (tick_cnt >= int'(timing.rx_bit_ticks)) begin
                  tick_cnt = 0;
                  phase = SEQ_IDLE;
                  ev = EV_BYTE_RECV;
                  byte_out = shift_byte;
               end
            end
            default: ;
         endcase
      end
      rsp.tx_level  = drive_level;
      rsp.busy_res  = (phase != SEQ_IDLE);
      rsp.event_res = ev;
      rsp.rx_data   = byte_out;
   endtask

   // Everything is sampled at the rising edge, where each handshake completes.
   always @(posedge clock) begin
      dali_cmd_type cmd;
      dali_rsp_type next_rsp;
      dali_rsp_type got;
      dali_rsp_type oldest;
      if (reset) begin
         clear_sequencer();
         owed_rsp.delete();
      end else begin
         // Register port: writes update the shadow, reads are compared with it.
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               write_timing(csr_paddr[4:2], csr_pwdata);
            end else if (csr_prdata != read_timing(csr_paddr[4:2])) begin
               report_mismatch("register read", csr_prdata, read_timing(csr_paddr[4:2]));
            end
         end
         if (req_tvalid && req_tready) begin
            cmd.func          = req_tuser;
            cmd.frame_address = req_tdata[7:0];
            cmd.frame_data    = req_tdata[15:8];
            cmd.wait_ms       = req_tdata[31:16];
            cmd.rx_level      = req_tdata[32];
            predict_word(cmd, next_rsp);
            owed_rsp.push_back(next_rsp);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.tx_level  = rsp_tdata[0];
            got.busy_res  = rsp_tdata[1];
            got.rx_data   = rsp_tdata[9:2];
            got.event_res = rsp_tuser;
            if (owed_rsp.size() == 0) begin
               report_mismatch("event of a response word with none owed", got.event_res,
                               EV_NONE);
            end else begin
               oldest = owed_rsp.pop_front();
               if (got.tx_level != oldest.tx_level) begin
                  report_mismatch("tx_level", got.tx_level, oldest.tx_level);
               end
               if (got.busy_res != oldest.busy_res) begin
                  report_mismatch("busy_res", got.busy_res, oldest.busy_res);
               end
               if (got.event_res != oldest.event_res) begin
                  report_mismatch("event_res", got.event_res, oldest.event_res);
               end
               if (got.rx_data != oldest.rx_data) begin
                  report_mismatch("rx_data", got.rx_data, oldest.rx_data);
               end
            end
         end
         if (end_of_test && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (owed_rsp.size() != 0) begin
               report_mismatch("response words never delivered", 0, owed_rsp.size());
            end
         end
      end
   end

endmodule

>>> tb/dali_frame_transceiver_core_tb.sv
// Testbench top for the DALI frame transceiver: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module dali_frame_transceiver_core_tb;
   import dali_pkg::*;

   // Func code the block ignores like a command.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned PHASE_WORDS = 140;

   typedef enum logic [1:0] {
      PACE_NONE,
      PACE_SENDER,
      PACE_RECEIVER,
      PACE_BOTH
   } pace_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // frame_address[7:0], frame_data[15:8],
                                  // wait_ms[31:16], rx_level[32], zero fill
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // tx_level[0], busy_res[1], rx_data[9:2], zero fill
   logic [1:0]  rsp_tuser;        // event_res[1:0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        end_of_test = 1'b0;
   int          failures;

   int unsigned  gap_pct = 0;
   int unsigned  stall_pct = 0;
   int unsigned  words_sent = 0;
   int unsigned  words_back = 0;
   int unsigned  quiet_cycles = 0;
   logic         last_busy = 1'b0;
   dali_cfg_type timing_now;
   pace_type     pace;

   dali_frame_transceiver_core dut (.*);

   dali_frame_transceiver_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Response side: random back-pressure at the configured rate.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Word counts for draining, and a watchdog on cycles where nothing moves.
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         words_sent <= words_sent + 1;
      end
      if (rsp_tvalid && rsp_tready) begin
         words_back <= words_back + 1;
         last_busy <= rsp_tdata[1];
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned at_least_one(input int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   // Offers one request word and returns at the falling edge after it is taken.
   task automatic put_word(input logic [1:0] func, input logic [7:0] addr,
                           input logic [7:0] data, input logic [15:0] tmo, input logic lvl);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {7'b0, lvl, tmo, data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // A time tick; the command fields it carries are don't-care and left random.
   task automatic tick(input logic lvl);
      put_word(FUNC_TICK, 8'($urandom), 8'($urandom), 16'($urandom), lvl);
   endtask

   // Now and then a command word that the busy block has to ignore.
   task automatic maybe_interject();
      logic [1:0] func;
      if ($urandom_range(0, 99) < 3) begin
         case ($urandom_range(0, 2))
            0:       func = FUNC_SEND;
            1:       func = FUNC_RECV;
            default: func = FUNC_UNUSED;
         endcase
         put_word(func, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   task automatic csr_access(input logic write, input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Writes all six registers, with junk above each field, then reads them back.
   task automatic load_timing(input dali_cfg_type t);
      timing_now = t;
      csr_access(1'b1, REG_TX_HALF,    {20'($urandom), t.tx_half_ticks});
      csr_access(1'b1, REG_RX_BIT,     {20'($urandom), t.rx_bit_ticks});
      csr_access(1'b1, REG_RX_HALF,    {20'($urandom), t.rx_half_ticks});
      csr_access(1'b1, REG_RX_QUARTER, {20'($urandom), t.rx_quarter_ticks});
      csr_access(1'b1, REG_STOP,       {16'($urandom), t.stop_ticks});
      csr_access(1'b1, REG_TICKS_MS,   {16'($urandom), t.ticks_per_ms});
      for (int i = REG_TX_HALF; i <= REG_TICKS_MS; i++) begin
         csr_access(1'b0, 3'(i), $urandom);
      end
   endtask

   // Stops offering words, waits for every owed response, then ticks until idle.
   task automatic quiesce();
      int unsigned spins;
      spins = 0;
      req_tvalid <= 1'b0;
      while (words_back != words_sent) @(negedge clock);
      while (last_busy && spins < 20000) begin
         tick(1'($urandom));
         req_tvalid <= 1'b0;
         while (words_back != words_sent) @(negedge clock);
         spins++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic set_pace(input pace_type p);
      case (p)
         PACE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
         PACE_SENDER:   begin gap_pct = 70; stall_pct = 0;  end
         PACE_RECEIVER: begin gap_pct = 0;  stall_pct = 70; end
         default:       begin gap_pct = 19; stall_pct = 19; end
      endcase
   endtask

   // Forward frame: the command, then exactly the ticks that 34 halves and the stop take.
   task automatic send_frame(input logic [7:0] addr, input logic [7:0] data);
      int unsigned n;
      put_word(FUNC_SEND, addr, data, 16'($urandom), 1'($urandom));
      n = 34 * at_least_one(timing_now.tx_half_ticks) + at_least_one(timing_now.stop_ticks);
      repeat (n) begin
         maybe_interject();
         tick(1'($urandom));
      end
   endtask

   // Backward frame: idle-high wait, falling edge, then the byte held in each bit window.
   task automatic receive_byte(input logic [15:0] tmo, input logic [7:0] value,
                               input int unsigned pre_low, input int unsigned pre_high);
      int unsigned first_at;
      int unsigned bit_span;
      int unsigned sample_no;
      put_word(FUNC_RECV, 8'($urandom), 8'($urandom), tmo, 1'($urandom));
      repeat (pre_low) tick(1'b0);
      repeat (pre_high) tick(1'b1);
      tick(1'b0);
      first_at = at_least_one(int'(timing_now.rx_bit_ticks) + int'(timing_now.rx_half_ticks)
                              + int'(timing_now.rx_quarter_ticks));
      bit_span = at_least_one(timing_now.rx_bit_ticks);
      for (int unsigned t = 1; t <= first_at + 8 * bit_span; t++) begin
         sample_no = (t <= first_at) ? 0 : (t - first_at + bit_span - 1) / bit_span;
         // Off the sampling point the line gets a little random noise.
         if (sample_no < 8 && (t == first_at + sample_no * bit_span
                               || $urandom_range(0, 9) != 0)) begin
            tick(value[7 - sample_no]);
         end else begin
            tick(1'($urandom));
         end
      end
   endtask

   // Receive that never sees the awaited level, so it has to run into its timeout.
   task automatic timeout_case(input logic [15:0] tmo, input logic stuck_high);
      put_word(FUNC_RECV, 8'($urandom), 8'($urandom), tmo, 1'($urandom));
      repeat (tmo * timing_now.ticks_per_ms + 2) tick(stuck_high);
   endtask

   function automatic dali_cfg_type random_timing();
      dali_cfg_type t;
      t.tx_half_ticks    = 12'($urandom_range(0, 3));
      t.rx_bit_ticks     = 12'($urandom_range(0, 4));
      t.rx_half_ticks    = 12'($urandom_range(0, 3));
      t.rx_quarter_ticks = 12'($urandom_range(0, 3));
      t.stop_ticks       = 16'($urandom_range(0, 8));
      t.ticks_per_ms     = 16'($urandom_range(0, 5));
      return t;
   endfunction

   // Mostly complete frames with random content; the rest is noise and broken receives.
   task automatic random_phase(input int unsigned words);
      int unsigned start;
      int unsigned pick;
      start = words_sent;
      while (words_sent - start < words) begin
         pick = $urandom_range(0, 99);
         if (pick < 42) begin
            send_frame(8'($urandom), 8'($urandom));
         end else if (pick < 78) begin
            receive_byte(16'($urandom), 8'($urandom), $urandom_range(0, 4),
                         $urandom_range(1, 4));
         end else if (pick < 88) begin
            timeout_case(16'($urandom_range(0, 3)), 1'($urandom));
         end else if (pick < 94) begin
            put_word(FUNC_RECV, 8'($urandom), 8'($urandom), 16'($urandom_range(0, 8)),
                     1'($urandom));
            repeat ($urandom_range(1, 20)) tick(1'($urandom));
         end else begin
            put_word(FUNC_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 4)) tick(1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_pace(PACE_NONE);
      timing_now = {TX_HALF_RST, RX_BIT_RST, RX_HALF_RST, RX_QUARTER_RST, STOP_RST,
                    TICKS_MS_RST};

      // Reset timing: idle ticks, an ignored code and receives with a zero timeout.
      tick(1'b1);
      put_word(FUNC_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
      timeout_case(16'd0, 1'b0);
      timeout_case(16'd0, 1'b1);
      quiesce();

      // Short timing: field extremes, zero timeouts and commands while busy.
      load_timing('{12'd1, 12'd2, 12'd1, 12'd1, 16'd2, 16'd2});
      send_frame(8'h00, 8'h00);
      send_frame(8'hFF, 8'hFF);
      receive_byte(16'd0, 8'h00, 0, 1);
      receive_byte(16'd1, 8'hFF, 1, 1);
      timeout_case(16'd0, 1'b0);
      timeout_case(16'd0, 1'b1);
      timeout_case(16'd2, 1'b0);
      timeout_case(16'd3, 1'b1);
      put_word(FUNC_SEND, 8'h81, 8'h7E, 16'd0, 1'b0);
      put_word(FUNC_SEND, 8'h00, 8'h00, 16'd0, 1'b0);
      put_word(FUNC_RECV, 8'h00, 8'h00, 16'd5, 1'b1);
      put_word(FUNC_UNUSED, 8'h00, 8'h00, 16'd0, 1'b0);
      repeat (34 + 2) tick(1'b1);
      quiesce();

      // Zero in every register: each count acts as one tick, the timeout as none.
      load_timing('{12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 16'd0});
      send_frame(8'h5A, 8'hC3);
      receive_byte(16'd5, 8'h5A, 0, 1);
      timeout_case(16'd1, 1'b0);
      quiesce();

      // Largest values of every register, with two receives that have a zero timeout.
      load_timing('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF});
      timeout_case(16'd0, 1'b0);
      timeout_case(16'd0, 1'b1);
      quiesce();

      // Smallest legal values.
      load_timing('{12'd1, 12'd1, 12'd1, 12'd0, 16'd1, 16'd1});
      random_phase(150);
      quiesce();

      // Random timing under each idling pattern.
      pace = pace.first();
      repeat (pace.num()) begin
         set_pace(pace);
         repeat (2) begin
            load_timing(random_timing());
            random_phase(PHASE_WORDS);
            quiesce();
         end
         pace = pace.next();
      end

      set_pace(PACE_NONE);
      quiesce();
      end_of_test <= 1'b1;
      @(negedge clock);
      @(negedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
